@@ sv/mfisap_pkg.sv @@
`timescale 1ns / 1ps
package mfisap_pkg;

  localparam int MAX_NODES  = 64;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int LABEL_W    = $clog2(MAX_NODES + 1);
  localparam int FLOW_W     = 48;
  localparam int CAP_W      = 32;
  localparam int RES_DEPTH  = MAX_NODES * MAX_NODES;
  localparam int RES_AW     = 2 * NODE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT  = 2'd0,
    CFG_SOURCE_NODE = 2'd1,
    CFG_SINK_NODE   = 2'd2
  } cfg_index_e;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [FLOW_W-1:0]  flow_t;

  function automatic flow_t sat_add(flow_t a, flow_t b);
    logic [FLOW_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[FLOW_W] ? FLOW_MAX : sum[FLOW_W-1:0];
  endfunction

endpackage

@@ sv/mfisap_if.sv @@
`timescale 1ns / 1ps
interface mfisap_edge_if;
  logic                            valid;
  logic                            ready;
  logic [6:0]                      edge_tail;
  logic [6:0]                      edge_head;
  logic [mfisap_pkg::CAP_W-1:0]    edge_capacity;
  logic                            last_edge;
  modport source(output valid, edge_tail, edge_head, edge_capacity, last_edge, input ready);
  modport sink(input valid, edge_tail, edge_head, edge_capacity, last_edge, output ready);
endinterface

interface mfisap_flow_if;
  logic                            valid;
  logic                            ready;
  logic [mfisap_pkg::FLOW_W-1:0]   max_flow;
  modport source(output valid, max_flow, input ready);
  modport sink(input valid, max_flow, output ready);
endinterface

interface mfisap_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [mfisap_pkg::CFG_IDX_W-1:0]    index;
  logic [mfisap_pkg::CFG_DATA_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ sv/mfisap_ram.sv @@
`timescale 1ns / 1ps
module mfisap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wa_i,
  input  logic [WIDTH-1:0]         wd_i,
  input  logic [$clog2(DEPTH)-1:0] ra_i,
  output logic [WIDTH-1:0]         rd_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    rd_q <= mem_q[ra_i];
  end

  assign rd_o = rd_q;

endmodule

@@ sv/max_flow_isap_matrix.sv @@
`timescale 1ns / 1ps
// Maximum flow engine. Edges arrive one per transaction and are summed, with saturation, into
// a 64 by 64 residual capacity memory; each edge reads its entry and writes it back, and the
// write is skipped when one of its nodes is out of range. The transaction that carries
// last_edge starts an ISAP search from the source to the sink: labels come from a reverse BFS,
// and every scan, relabel and augmenting step walks the nodes one memory read at a time, as the
// residual memory has a single read port. The total is then offered on the result channel, or
// zero with no search when the source or sink lies outside the node count or they are equal,
// and all 4096 entries of the residual memory are cleared, one entry per cycle, before the next
// edge is taken. The same clearing pass runs after reset. Configuration writes are taken at
// any time but must only be issued while the block is idle.
module max_flow_isap_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  mfisap_edge_if.sink    edge_in,
  mfisap_flow_if.source  flow_out,
  mfisap_cfg_if.sink     cfg_in
);

  typedef enum logic [35:0] {
    S_IDLE  = 36'd1 << 0,  S_ERD  = 36'd1 << 1,  S_EWR = 36'd1 << 2,  S_START = 36'd1 << 3,
    S_INIT  = 36'd1 << 4,  S_BT   = 36'd1 << 5,  S_BHD = 36'd1 << 6,  S_BHU   = 36'd1 << 7,
    S_BHL   = 36'd1 << 8,  S_BV   = 36'd1 << 9,  S_BC  = 36'd1 << 10, S_GL    = 36'd1 << 11,
    S_GG    = 36'd1 << 12, S_GW   = 36'd1 << 13, S_PREP = 36'd1 << 14, S_TOP  = 36'd1 << 15,
    S_AN    = 36'd1 << 16, S_AB   = 36'd1 << 17, S_AW1 = 36'd1 << 18, S_AR2   = 36'd1 << 19,
    S_AW2   = 36'd1 << 20, S_SC0  = 36'd1 << 21, S_SC1 = 36'd1 << 22, S_SV    = 36'd1 << 23,
    S_SC    = 36'd1 << 24, S_R0   = 36'd1 << 25, S_RV  = 36'd1 << 26, S_RC    = 36'd1 << 27,
    S_RG    = 36'd1 << 28, S_RD   = 36'd1 << 29, S_RL  = 36'd1 << 30, S_RI    = 36'd1 << 31,
    S_RP    = 36'd1 << 32, S_RQ   = 36'd1 << 33, S_EMIT = 36'd1 << 34, S_CLR  = 36'd1 << 35
  } state_e;

  localparam int LW = mfisap_pkg::LABEL_W;
  localparam int NW = mfisap_pkg::NODE_W;
  localparam int FW = mfisap_pkg::FLOW_W;
  localparam int AW = mfisap_pkg::RES_AW;
  localparam logic [LW-1:0] NODES = LW'(mfisap_pkg::MAX_NODES);
  localparam logic [NW-1:0] TOP_DEPTH = {NW{1'b1}};

  state_e state_q, state_d;

  logic [LW-1:0] nc_q, src_q, snk_q;
  logic [LW-1:0] tl_q, hd_q;
  logic [mfisap_pkg::CAP_W-1:0] cap_q;
  logic last_q;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] head_q, head_d, tail_q, tail_d, v_q, v_d;
  logic [LW-1:0] lu_q, lu_d, ls_q, ls_d, minl_q, minl_d, gl_q, gl_d;
  logic [NW-1:0] u_q, u_d, depth_q, depth_d, k_q, k_d, a_q, a_d, b_q, b_d;
  logic [FW-1:0] f_q, f_d, total_q, total_d, od_q, od_d;
  logic ov_q, ov_d;

  logic res_we; logic [AW-1:0] res_wa, res_ra; logic [FW-1:0] res_wd, res_rd;
  logic lab_we; logic [NW-1:0] lab_wa, lab_ra; logic [LW-1:0] lab_wd, lab_rd;
  logic gap_we; logic [LW-1:0] gap_wa, gap_ra; logic [LW-1:0] gap_wd, gap_rd;
  logic scn_we; logic [NW-1:0] scn_wa, scn_ra; logic [LW-1:0] scn_wd, scn_rd;
  logic pn_we;  logic [NW-1:0] pn_wa, pn_ra;   logic [NW-1:0] pn_wd, pn_rd;
  logic pf_we;  logic [NW-1:0] pf_wa, pf_ra;   logic [FW-1:0] pf_wd, pf_rd;

  logic [LW-1:0] n_eff;
  logic          bad_ends, edge_ok, in_acc;
  logic [NW-1:0] s_node, t_node, tl_node, hd_node;
  logic [FW-1:0] fmin;
  logic [LW-1:0] gap_dec;

  mfisap_ram #(.WIDTH(FW), .DEPTH(mfisap_pkg::RES_DEPTH)) u_res (
    .clk_i, .we_i(res_we), .wa_i(res_wa), .wd_i(res_wd), .ra_i(res_ra), .rd_o(res_rd));
  mfisap_ram #(.WIDTH(LW), .DEPTH(mfisap_pkg::MAX_NODES)) u_lab (
    .clk_i, .we_i(lab_we), .wa_i(lab_wa), .wd_i(lab_wd), .ra_i(lab_ra), .rd_o(lab_rd));
  mfisap_ram #(.WIDTH(LW), .DEPTH(mfisap_pkg::MAX_NODES + 1)) u_gap (
    .clk_i, .we_i(gap_we), .wa_i(gap_wa), .wd_i(gap_wd), .ra_i(gap_ra), .rd_o(gap_rd));
  mfisap_ram #(.WIDTH(LW), .DEPTH(mfisap_pkg::MAX_NODES)) u_scn (
    .clk_i, .we_i(scn_we), .wa_i(scn_wa), .wd_i(scn_wd), .ra_i(scn_ra), .rd_o(scn_rd));
  mfisap_ram #(.WIDTH(NW), .DEPTH(mfisap_pkg::MAX_NODES)) u_pn (
    .clk_i, .we_i(pn_we), .wa_i(pn_wa), .wd_i(pn_wd), .ra_i(pn_ra), .rd_o(pn_rd));
  mfisap_ram #(.WIDTH(FW), .DEPTH(mfisap_pkg::MAX_NODES)) u_pf (
    .clk_i, .we_i(pf_we), .wa_i(pf_wa), .wd_i(pf_wd), .ra_i(pf_ra), .rd_o(pf_rd));

  assign edge_in.ready   = (state_q == S_IDLE);
  assign in_acc          = edge_in.valid && edge_in.ready;
  assign cfg_in.ready    = 1'b1;
  assign flow_out.valid  = ov_q;
  assign flow_out.max_flow = od_q;

  assign n_eff = (nc_q < LW'(2)) ? LW'(2) : ((nc_q > NODES) ? NODES : nc_q);
  assign bad_ends = (src_q == '0) || (src_q > n_eff) || (snk_q == '0) || (snk_q > n_eff) ||
                    (src_q == snk_q);
  assign s_node  = NW'(src_q - LW'(1));
  assign t_node  = NW'(snk_q - LW'(1));
  assign tl_node = NW'(tl_q - LW'(1));
  assign hd_node = NW'(hd_q - LW'(1));
  assign edge_ok = (tl_q != '0) && (tl_q <= NODES) && (hd_q != '0) && (hd_q <= NODES);
  assign fmin    = (f_q < res_rd) ? f_q : res_rd;
  assign gap_dec = gap_rd - LW'(1);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; head_d = head_q; tail_d = tail_q; v_d = v_q;
    lu_d = lu_q; ls_d = ls_q; minl_d = minl_q; gl_d = gl_q;
    u_d = u_q; depth_d = depth_q; k_d = k_q; a_d = a_q; b_d = b_q;
    f_d = f_q; total_d = total_q; od_d = od_q;
    ov_d = ov_q && !flow_out.ready;

    res_we = 1'b0; res_wa = '0; res_wd = '0; res_ra = '0;
    lab_we = 1'b0; lab_wa = '0; lab_wd = '0; lab_ra = '0;
    gap_we = 1'b0; gap_wa = '0; gap_wd = '0; gap_ra = '0;
    scn_we = 1'b0; scn_wa = '0; scn_wd = '0; scn_ra = '0;
    pn_we  = 1'b0; pn_wa  = '0; pn_wd  = '0; pn_ra  = '0;
    pf_we  = 1'b0; pf_wa  = '0; pf_wd  = '0; pf_ra  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_ERD;
        end
      end
      S_ERD: begin
        res_ra = {tl_node, hd_node};
        if (edge_ok) begin
          state_d = S_EWR;
        end else begin
          state_d = last_q ? S_START : S_IDLE;
        end
      end
      S_EWR: begin
        res_we = 1'b1;
        res_wa = {tl_node, hd_node};
        res_wd = mfisap_pkg::sat_add(res_rd, FW'(cap_q));
        state_d = last_q ? S_START : S_IDLE;
      end
      S_START: begin
        cnt_d = '0;
        total_d = '0;
        state_d = bad_ends ? S_EMIT : S_INIT;
      end
      S_INIT: begin
        lab_we = (cnt_q[LW-1:0] < NODES);
        lab_wa = cnt_q[NW-1:0];
        lab_wd = n_eff;
        scn_we = lab_we;
        scn_wa = cnt_q[NW-1:0];
        gap_we = 1'b1;
        gap_wa = cnt_q[LW-1:0];
        pf_we  = 1'b1;
        pf_wd  = mfisap_pkg::FLOW_MAX;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_q[LW-1:0] == NODES) begin
          state_d = S_BT;
        end
      end
      S_BT: begin
        lab_we = 1'b1;
        lab_wa = t_node;
        pn_we  = 1'b1;
        pn_wd  = t_node;
        head_d = '0;
        tail_d = LW'(1);
        ls_d   = n_eff;
        state_d = S_BHD;
      end
      S_BHD: begin
        pn_ra = head_q[NW-1:0];
        if (head_q < tail_q) begin
          state_d = S_BHU;
        end else begin
          cnt_d = '0;
          state_d = S_GL;
        end
      end
      S_BHU: begin
        lab_ra = pn_rd;
        u_d = pn_rd;
        state_d = S_BHL;
      end
      S_BHL: begin
        lu_d = lab_rd;
        v_d = '0;
        state_d = S_BV;
      end
      S_BV: begin
        lab_ra = v_q[NW-1:0];
        res_ra = {v_q[NW-1:0], u_q};
        state_d = S_BC;
      end
      S_BC: begin
        if ((v_q[NW-1:0] != t_node) && (lab_rd == n_eff) && (res_rd != '0) &&
            (tail_q < NODES)) begin
          lab_we = 1'b1;
          lab_wa = v_q[NW-1:0];
          lab_wd = lu_q + LW'(1);
          pn_we  = 1'b1;
          pn_wa  = tail_q[NW-1:0];
          pn_wd  = v_q[NW-1:0];
          tail_d = tail_q + LW'(1);
          if (v_q[NW-1:0] == s_node) begin
            ls_d = lu_q + LW'(1);
          end
        end
        v_d = v_q + LW'(1);
        if (v_q == n_eff - LW'(1)) begin
          head_d = head_q + LW'(1);
          state_d = S_BHD;
        end else begin
          state_d = S_BV;
        end
      end
      S_GL: begin
        lab_ra = cnt_q[NW-1:0];
        state_d = S_GG;
      end
      S_GG: begin
        gap_ra = lab_rd;
        gl_d = lab_rd;
        state_d = S_GW;
      end
      S_GW: begin
        gap_we = 1'b1;
        gap_wa = gl_q;
        gap_wd = gap_rd + LW'(1);
        cnt_d = cnt_q + AW'(1);
        if (cnt_q[LW-1:0] == n_eff - LW'(1)) begin
          state_d = S_PREP;
        end else begin
          state_d = S_GL;
        end
      end
      S_PREP: begin
        pn_we = 1'b1;
        pn_wd = s_node;
        depth_d = '0;
        u_d = s_node;
        f_d = mfisap_pkg::FLOW_MAX;
        total_d = '0;
        state_d = S_TOP;
      end
      S_TOP: begin
        if (ls_q >= n_eff) begin
          state_d = S_EMIT;
        end else if (u_q == t_node) begin
          k_d = '0;
          a_d = s_node;
          state_d = S_AN;
        end else begin
          state_d = S_SC0;
        end
      end
      S_AN: begin
        pn_ra = k_q + NW'(1);
        state_d = S_AB;
      end
      S_AB: begin
        b_d = pn_rd;
        res_ra = {a_q, pn_rd};
        state_d = S_AW1;
      end
      S_AW1: begin
        res_we = 1'b1;
        res_wa = {a_q, b_q};
        res_wd = res_rd - f_q;
        state_d = S_AR2;
      end
      S_AR2: begin
        res_ra = {b_q, a_q};
        state_d = S_AW2;
      end
      S_AW2: begin
        res_we = 1'b1;
        res_wa = {b_q, a_q};
        res_wd = mfisap_pkg::sat_add(res_rd, f_q);
        a_d = b_q;
        k_d = k_q + NW'(1);
        if (k_q + NW'(1) == depth_q) begin
          total_d = mfisap_pkg::sat_add(total_q, f_q);
          depth_d = '0;
          u_d = s_node;
          f_d = mfisap_pkg::FLOW_MAX;
          state_d = S_TOP;
        end else begin
          state_d = S_AN;
        end
      end
      S_SC0: begin
        scn_ra = u_q;
        lab_ra = u_q;
        state_d = S_SC1;
      end
      S_SC1: begin
        v_d = scn_rd;
        lu_d = lab_rd;
        state_d = S_SV;
      end
      S_SV: begin
        lab_ra = v_q[NW-1:0];
        res_ra = {u_q, v_q[NW-1:0]};
        state_d = (v_q >= n_eff) ? S_R0 : S_SC;
      end
      S_SC: begin
        if ((res_rd != '0) && (lu_q == lab_rd + LW'(1))) begin
          if (depth_q != TOP_DEPTH) begin
            scn_we = 1'b1;
            scn_wa = u_q;
            scn_wd = v_q;
            pn_we  = 1'b1;
            pn_wa  = depth_q + NW'(1);
            pn_wd  = v_q[NW-1:0];
            pf_we  = 1'b1;
            pf_wa  = depth_q + NW'(1);
            pf_wd  = fmin;
            depth_d = depth_q + NW'(1);
            u_d = v_q[NW-1:0];
            f_d = fmin;
            state_d = S_TOP;
          end else begin
            state_d = S_R0;
          end
        end else begin
          v_d = v_q + LW'(1);
          state_d = S_SV;
        end
      end
      S_R0: begin
        v_d = '0;
        minl_d = n_eff - LW'(1);
        state_d = S_RV;
      end
      S_RV: begin
        lab_ra = v_q[NW-1:0];
        res_ra = {u_q, v_q[NW-1:0]};
        state_d = S_RC;
      end
      S_RC: begin
        if ((res_rd != '0) && (lab_rd < minl_q)) begin
          minl_d = lab_rd;
        end
        v_d = v_q + LW'(1);
        state_d = (v_q == n_eff - LW'(1)) ? S_RG : S_RV;
      end
      S_RG: begin
        gap_ra = lu_q;
        state_d = S_RD;
      end
      S_RD: begin
        gap_we = 1'b1;
        gap_wa = lu_q;
        gap_wd = gap_dec;
        state_d = (gap_dec == '0) ? S_EMIT : S_RL;
      end
      S_RL: begin
        lab_we = 1'b1;
        lab_wa = u_q;
        lab_wd = minl_q + LW'(1);
        scn_we = 1'b1;
        scn_wa = u_q;
        gap_ra = minl_q + LW'(1);
        if (u_q == s_node) begin
          ls_d = minl_q + LW'(1);
        end
        state_d = S_RI;
      end
      S_RI: begin
        gap_we = 1'b1;
        gap_wa = minl_q + LW'(1);
        gap_wd = gap_rd + LW'(1);
        if (depth_q != '0) begin
          depth_d = depth_q - NW'(1);
        end
        state_d = S_RP;
      end
      S_RP: begin
        pn_ra = depth_q;
        pf_ra = depth_q;
        state_d = S_RQ;
      end
      S_RQ: begin
        u_d = pn_rd;
        f_d = pf_rd;
        state_d = S_TOP;
      end
      S_EMIT: begin
        if (!ov_q || flow_out.ready) begin
          ov_d = 1'b1;
          od_d = bad_ends ? '0 : total_q;
          cnt_d = '0;
          state_d = S_CLR;
        end
      end
      S_CLR: begin
        res_we = 1'b1;
        res_wa = cnt_q;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == {AW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      nc_q    <= NODES;
      src_q   <= LW'(1);
      snk_q   <= NODES;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (cfg_in.valid && cfg_in.ready) begin
        unique case (cfg_in.index)
          mfisap_pkg::CFG_NODE_COUNT:  nc_q  <= cfg_in.data;
          mfisap_pkg::CFG_SOURCE_NODE: src_q <= cfg_in.data;
          mfisap_pkg::CFG_SINK_NODE:   snk_q <= cfg_in.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tl_q   <= edge_in.edge_tail;
      hd_q   <= edge_in.edge_head;
      cap_q  <= edge_in.edge_capacity;
      last_q <= edge_in.last_edge;
    end
    head_q  <= head_d;
    tail_q  <= tail_d;
    v_q     <= v_d;
    lu_q    <= lu_d;
    ls_q    <= ls_d;
    minl_q  <= minl_d;
    gl_q    <= gl_d;
    u_q     <= u_d;
    depth_q <= depth_d;
    k_q     <= k_d;
    a_q     <= a_d;
    b_q     <= b_d;
    f_q     <= f_d;
    total_q <= total_d;
    od_q    <= od_d;
  end

endmodule

@@ sv/mfisap_checker.sv @@
`timescale 1ns / 1ps
module mfisap_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [mfisap_pkg::FLOW_W-1:0] out_data_i
);

  // Every edge needs at least a read of the matrix, so a transaction is never followed
  // by another in the next cycle.
  a_busy_after_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("edge channel ready right after a transaction");

  // A result appears only while the block is working on a graph.
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i)
    else $error("result raised while the edge channel was ready");

  // The edge channel stays closed while a result is offered for the first time.
  a_no_edge_with_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !$past(out_valid_i)) |-> !(in_valid_i && in_ready_i))
    else $error("edge accepted in the cycle a result appeared");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed");

endmodule

bind max_flow_isap_matrix mfisap_checker u_mfisap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (edge_in.valid),
  .in_ready_i  (edge_in.ready),
  .out_valid_i (flow_out.valid),
  .out_ready_i (flow_out.ready),
  .out_data_i  (flow_out.max_flow)
);

@@ test/max_flow_isap_matrix_test.sv @@
`timescale 1ns / 1ps
module max_flow_isap_matrix_test;

  typedef logic [mfisap_pkg::FLOW_W-1:0] amount_t;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE_CYCLES = 4400;
  localparam int TARGET_EDGES = 1050;

  class flow_scoreboard;
    amount_t cap_mat[mfisap_pkg::MAX_NODES][mfisap_pkg::MAX_NODES];
    int node_cnt = 64;
    int src = 1;
    int snk = 64;
    amount_t pending_flows[$];
    int errors = 0;

    function amount_t cap_sum(amount_t a, amount_t b);
      logic [mfisap_pkg::FLOW_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[mfisap_pkg::FLOW_W] ? mfisap_pkg::FLOW_MAX : s[mfisap_pkg::FLOW_W-1:0];
    endfunction

    function void set_reg(mfisap_pkg::cfg_index_e idx, logic [6:0] value);
      case (idx)
        mfisap_pkg::CFG_NODE_COUNT: node_cnt = value;
        mfisap_pkg::CFG_SOURCE_NODE: src = value;
        mfisap_pkg::CFG_SINK_NODE: snk = value;
        default: ;
      endcase
    endfunction

    function amount_t solve_max_flow();
      int n, s, t, head, tl, depth, u, v, minl, a, b, k;
      int lbl[mfisap_pkg::MAX_NODES];
      int gapc[mfisap_pkg::MAX_NODES+1];
      int pnode[mfisap_pkg::MAX_NODES];
      int scan[mfisap_pkg::MAX_NODES];
      int q[mfisap_pkg::MAX_NODES];
      amount_t pflow[mfisap_pkg::MAX_NODES];
      amount_t f, tot;
      n = node_cnt;
      if (n < 2) n = 2;
      if (n > mfisap_pkg::MAX_NODES) n = mfisap_pkg::MAX_NODES;
      if (src < 1 || src > n || snk < 1 || snk > n || src == snk) return '0;
      s = src - 1;
      t = snk - 1;
      for (int i = 0; i < n; i++) begin
        lbl[i] = n;
        scan[i] = 0;
      end
      for (int i = 0; i <= n; i++) gapc[i] = 0;
      lbl[t] = 0;
      q[0] = t;
      head = 0;
      tl = 1;
      while (head < tl) begin
        u = q[head];
        head++;
        for (v = 0; v < n; v++) begin
          if (v != t && lbl[v] == n && cap_mat[v][u] != 0 && tl < mfisap_pkg::MAX_NODES) begin
            lbl[v] = lbl[u] + 1;
            q[tl] = v;
            tl++;
          end
        end
      end
      for (int i = 0; i < n; i++) gapc[lbl[i]]++;
      tot = '0;
      depth = 0;
      pnode[0] = s;
      pflow[0] = mfisap_pkg::FLOW_MAX;
      while (lbl[s] < n) begin
        u = pnode[depth];
        if (u == t) begin
          f = pflow[depth];
          for (k = 0; k < depth; k++) begin
            a = pnode[k];
            b = pnode[k+1];
            cap_mat[a][b] = cap_mat[a][b] - f;
            cap_mat[b][a] = cap_sum(cap_mat[b][a], f);
          end
          tot = cap_sum(tot, f);
          depth = 0;
          continue;
        end
        for (v = scan[u]; v < n; v++)
          if (cap_mat[u][v] != 0 && lbl[u] == lbl[v] + 1) break;
        if (v < n && depth + 1 < mfisap_pkg::MAX_NODES) begin
          scan[u] = v;
          f = cap_mat[u][v];
          if (pflow[depth] < f) f = pflow[depth];
          depth++;
          pnode[depth] = v;
          pflow[depth] = f;
          continue;
        end
        minl = n - 1;
        for (v = 0; v < n; v++)
          if (cap_mat[u][v] != 0 && lbl[v] < minl) minl = lbl[v];
        gapc[lbl[u]]--;
        if (gapc[lbl[u]] == 0) break;
        lbl[u] = minl + 1;
        gapc[lbl[u]]++;
        scan[u] = 0;
        if (depth > 0) depth--;
      end
      return tot;
    endfunction

    function void note_edge(logic [6:0] tl, logic [6:0] hd, logic [31:0] c, logic last);
      if (tl >= 1 && tl <= mfisap_pkg::MAX_NODES && hd >= 1 && hd <= mfisap_pkg::MAX_NODES)
        cap_mat[tl-1][hd-1] = cap_sum(cap_mat[tl-1][hd-1], {16'b0, c});
      if (last) begin
        pending_flows = {pending_flows, solve_max_flow()};
        foreach (cap_mat[i, j]) cap_mat[i][j] = '0;
      end
    endfunction

    function void check_flow(amount_t got);
      amount_t want;
      if (pending_flows.size() == 0) begin
        $display("%0t: unexpected max_flow transaction, got %0d", $time, got);
        errors++;
        return;
      end
      want = pending_flows.pop_front();
      if (got !== want) begin
        $display("%0t: max_flow mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  mfisap_edge_if edge_bus();
  mfisap_flow_if flow_bus();
  mfisap_cfg_if cfg_bus();

  flow_scoreboard sb = new();
  int cycles = 0;
  int edges_sent = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit no_gaps = 0;
  int eff_nodes = 64;

  max_flow_isap_matrix dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .edge_in(edge_bus),
    .flow_out(flow_bus),
    .cfg_in(cfg_bus)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("max_flow_isap_matrix regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && flow_bus.valid && flow_bus.ready) sb.check_flow(flow_bus.max_flow);
  end

  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = 6000;
    end
    if (hold_left > 0) begin
      hold_left--;
      flow_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      flow_bus.ready <= 1'b0;
    end else if (no_gaps) begin
      flow_bus.ready <= 1'b1;
    end else if (r < 4) begin
      stall_left = $urandom_range(10, 60);
      flow_bus.ready <= 1'b0;
    end else if (r < 30) begin
      flow_bus.ready <= 1'b0;
    end else begin
      flow_bus.ready <= 1'b1;
    end
  end

  function int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_edge(logic [6:0] tl, logic [6:0] hd, logic [31:0] c, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      edge_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    edge_bus.valid <= 1'b1;
    edge_bus.edge_tail <= tl;
    edge_bus.edge_head <= hd;
    edge_bus.edge_capacity <= c;
    edge_bus.last_edge <= last;
    do @(posedge clk_i); while (!edge_bus.ready);
    sb.note_edge(tl, hd, c, last);
    edges_sent++;
  endtask

  task automatic go_idle();
    edge_bus.valid <= 1'b0;
    while (sb.pending_flows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(mfisap_pkg::cfg_index_e idx, logic [6:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.set_reg(idx, value);
  endtask

  task automatic set_graph_regs(logic [6:0] n, logic [6:0] s, logic [6:0] t);
    go_idle();
    write_reg(mfisap_pkg::CFG_NODE_COUNT, n);
    write_reg(mfisap_pkg::CFG_SOURCE_NODE, s);
    write_reg(mfisap_pkg::CFG_SINK_NODE, t);
    cfg_bus.valid <= 1'b0;
    eff_nodes = (n < 2) ? 2 : (n > mfisap_pkg::MAX_NODES) ? mfisap_pkg::MAX_NODES : n;
  endtask

  function logic [6:0] pick_node();
    if ($urandom_range(0, 99) < 6) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, eff_nodes));
  endfunction

  function logic [31:0] pick_capacity();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom_range(1, 20);
    if (r < 43) return '0;
    if (r < 53) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_graph(int count);
    for (int i = 0; i < count; i++)
      send_edge(pick_node(), pick_node(), pick_capacity(), i == count - 1);
  endtask

  initial begin
    int n, s, t;
    rst_ni = 1'b0;
    edge_bus.valid = 1'b0;
    edge_bus.edge_tail = '0;
    edge_bus.edge_head = '0;
    edge_bus.edge_capacity = '0;
    edge_bus.last_edge = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = mfisap_pkg::CFG_NODE_COUNT;
    cfg_bus.data = '0;
    flow_bus.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers at their reset values: full node range, source 1, sink 64.
    send_edge(7'd1, 7'd64, 32'hFFFF_FFFF, 1'b1);
    send_edge(7'd1, 7'd64, 32'hFFFF_FFFF, 1'b0);
    send_edge(7'd1, 7'd64, 32'hFFFF_FFFF, 1'b0);
    send_edge(7'd1, 7'd64, 32'hFFFF_FFFF, 1'b1);
    send_edge(7'd1, 7'd2, 32'hFFFF_FFFF, 1'b0);
    send_edge(7'd2, 7'd64, 32'd5, 1'b0);
    send_edge(7'd0, 7'd64, 32'd9, 1'b1);
    send_edge(7'd1, 7'd1, 32'd7, 1'b0);
    send_edge(7'd1, 7'd127, 32'd7, 1'b0);
    send_edge(7'd65, 7'd64, 32'd7, 1'b1);

    set_graph_regs(7'd4, 7'd1, 7'd4);
    send_edge(7'd1, 7'd2, 32'd3, 1'b0);
    send_edge(7'd2, 7'd4, 32'd4, 1'b0);
    send_edge(7'd1, 7'd3, 32'd6, 1'b0);
    send_edge(7'd3, 7'd2, 32'd2, 1'b0);
    send_edge(7'd5, 7'd4, 32'd9, 1'b0);
    send_edge(7'd3, 7'd4, 32'd1, 1'b1);
    send_edge(7'd4, 7'd1, 32'd8, 1'b1);

    set_graph_regs(7'd0, 7'd1, 7'd2);
    send_edge(7'd1, 7'd2, 32'd11, 1'b1);
    set_graph_regs(7'd127, 7'd64, 7'd1);
    send_edge(7'd64, 7'd1, 32'd13, 1'b1);
    set_graph_regs(7'd8, 7'd3, 7'd3);
    send_edge(7'd3, 7'd3, 32'd2, 1'b1);
    set_graph_regs(7'd8, 7'd0, 7'd100);
    send_edge(7'd1, 7'd8, 32'd2, 1'b1);

    for (int phase = 0; edges_sent < TARGET_EDGES; phase++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(2, 12);
      else if (r < 85) n = $urandom_range(13, 64);
      else n = $urandom_range(0, 127);
      s = (n < 2) ? 2 : (n > mfisap_pkg::MAX_NODES) ? mfisap_pkg::MAX_NODES : n;
      t = $urandom_range(1, s);
      s = $urandom_range(1, s);
      if ($urandom_range(0, 9) == 0) t = $urandom_range(0, 127);
      set_graph_regs(n[6:0], s[6:0], t[6:0]);
      no_gaps = (phase % 5 == 3);
      if (phase == 2) hold_requests++;
      for (int g = $urandom_range(2, 6); g > 0 && edges_sent < TARGET_EDGES; g--) begin
        if (eff_nodes > 16 && $urandom_range(0, 3) != 0)
          send_graph($urandom_range(1, 40));
        else
          send_graph($urandom_range(1, 14));
      end
    end
    no_gaps = 0;

    go_idle();
    if (sb.errors == 0 && sb.pending_flows.size() == 0) begin
      $display("max_flow_isap_matrix regression: pass");
    end else begin
      $display("max_flow_isap_matrix regression: fail");
    end
    $finish;
  end

endmodule
